// File: rtl/core/kbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_pkg: shared types and constants for the scancode decoder
// Make codes, special key numbers and the set 1 translation tables.
// ----------------------------------------------------------------------------
package kbd_pkg;

    // Modifier state carried between the decoder and the top level.
    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    // Result of decoding one byte.
    typedef struct packed {
        logic       emit;
        logic [8:0] key_value;
        logic       is_press;
    } dec_event_t;

    localparam logic [7:0] RELEASE_MASK = 8'h80;

    // Make codes with a fixed meaning.
    localparam logic [6:0] MK_LSHIFT = 7'h2a;
    localparam logic [6:0] MK_RSHIFT = 7'h36;
    localparam logic [6:0] MK_CTRL   = 7'h1d;
    localparam logic [6:0] MK_ALT    = 7'h38;
    localparam logic [6:0] MK_CAPS   = 7'h3a;
    localparam logic [6:0] MK_F1     = 7'h3b;
    localparam logic [6:0] MK_F10    = 7'h44;
    localparam logic [6:0] MK_HOME   = 7'h47;
    localparam logic [6:0] MK_UP     = 7'h48;
    localparam logic [6:0] MK_PGUP   = 7'h49;
    localparam logic [6:0] MK_LEFT   = 7'h4b;
    localparam logic [6:0] MK_RIGHT  = 7'h4d;
    localparam logic [6:0] MK_END    = 7'h4f;
    localparam logic [6:0] MK_DOWN   = 7'h50;
    localparam logic [6:0] MK_PGDN   = 7'h51;
    localparam logic [6:0] MK_INSERT = 7'h52;
    localparam logic [6:0] MK_DELETE = 7'h53;
    localparam logic [6:0] MK_F11    = 7'h57;
    localparam logic [6:0] MK_F12    = 7'h58;

    // Special key values reported in key_value.
    localparam logic [8:0] KV_HOME   = 9'd256;
    localparam logic [8:0] KV_UP     = 9'd257;
    localparam logic [8:0] KV_PGUP   = 9'd258;
    localparam logic [8:0] KV_LEFT   = 9'd259;
    localparam logic [8:0] KV_RIGHT  = 9'd260;
    localparam logic [8:0] KV_END    = 9'd261;
    localparam logic [8:0] KV_DOWN   = 9'd262;
    localparam logic [8:0] KV_PGDN   = 9'd263;
    localparam logic [8:0] KV_INSERT = 9'd264;
    localparam logic [8:0] KV_DELETE = 9'd265;
    localparam logic [8:0] KV_F1     = 9'd266;
    localparam logic [8:0] KV_F11    = 9'd276;
    localparam logic [8:0] KV_F12    = 9'd277;
    localparam logic [8:0] KV_LSHIFT = 9'd278;
    localparam logic [8:0] KV_LCTRL  = 9'd279;
    localparam logic [8:0] KV_LALT   = 9'd280;
    localparam logic [8:0] KV_CAPS   = 9'd281;

    // ASCII bounds and case offsets.
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7a;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_UPPER_Z = 7'h5a;
    localparam logic [6:0] CASE_OFFSET   = 7'd32;
    localparam logic [6:0] CTRL_OFFSET   = 7'd96;

    // Output stream layout.
    localparam int M_TDATA_W = 24;

    // Tables cover make codes 0x00..0x3a, padded with zeros to 64 entries.
    localparam logic [6:0] PLAIN_MAP [0:63] = '{
        7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFTED_MAP [0:63] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

// File: rtl/core/kbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_decode: combinational translation of one scancode byte
// Produces the key event and the next modifier state from the current one.
// ----------------------------------------------------------------------------
module kbd_decode (
    input  logic [7:0]          scan_byte,
    input  kbd_pkg::mod_flags_t flags,
    output kbd_pkg::dec_event_t dec_event,
    output kbd_pkg::mod_flags_t flags_next
);

    logic       press;
    logic [6:0] mk;
    logic [8:0] nav_key;
    logic       nav_hit;
    logic [3:0] f_offset;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    logic [6:0] c3;

    assign press = ((scan_byte & kbd_pkg::RELEASE_MASK) == 8'h00);
    assign mk    = scan_byte[6:0];
    assign f_offset = 4'(mk - kbd_pkg::MK_F1);

    // Navigation and function keys.
    always_comb begin
        nav_hit = 1'b1;
        case (mk)
            kbd_pkg::MK_HOME:   nav_key = kbd_pkg::KV_HOME;
            kbd_pkg::MK_UP:     nav_key = kbd_pkg::KV_UP;
            kbd_pkg::MK_PGUP:   nav_key = kbd_pkg::KV_PGUP;
            kbd_pkg::MK_LEFT:   nav_key = kbd_pkg::KV_LEFT;
            kbd_pkg::MK_RIGHT:  nav_key = kbd_pkg::KV_RIGHT;
            kbd_pkg::MK_END:    nav_key = kbd_pkg::KV_END;
            kbd_pkg::MK_DOWN:   nav_key = kbd_pkg::KV_DOWN;
            kbd_pkg::MK_PGDN:   nav_key = kbd_pkg::KV_PGDN;
            kbd_pkg::MK_INSERT: nav_key = kbd_pkg::KV_INSERT;
            kbd_pkg::MK_DELETE: nav_key = kbd_pkg::KV_DELETE;
            kbd_pkg::MK_F11:    nav_key = kbd_pkg::KV_F11;
            kbd_pkg::MK_F12:    nav_key = kbd_pkg::KV_F12;
            default: begin
                nav_key = kbd_pkg::KV_F1 + {5'b0, f_offset};
                nav_hit = (mk >= kbd_pkg::MK_F1) && (mk <= kbd_pkg::MK_F10);
            end
        endcase
    end

    // Character path: table, caps-lock case rules, then ctrl letters.
    always_comb begin
        c0 = flags.shift ? kbd_pkg::SHIFTED_MAP[mk[5:0]] : kbd_pkg::PLAIN_MAP[mk[5:0]];
        c1 = c0;
        if (flags.caps && c0 >= kbd_pkg::ASCII_LOWER_A && c0 <= kbd_pkg::ASCII_LOWER_Z) begin
            c1 = c0 - kbd_pkg::CASE_OFFSET;
        end
        c2 = c1;
        if (flags.caps && flags.shift && c1 >= kbd_pkg::ASCII_UPPER_A
            && c1 <= kbd_pkg::ASCII_UPPER_Z) begin
            c2 = c1 + kbd_pkg::CASE_OFFSET;
        end
        c3 = c2;
        if (flags.ctrl && c2 >= kbd_pkg::ASCII_LOWER_A && c2 <= kbd_pkg::ASCII_LOWER_Z) begin
            c3 = c2 - kbd_pkg::CTRL_OFFSET;
        end
    end

    always_comb begin
        flags_next         = flags;
        dec_event.is_press = press;
        dec_event.emit     = 1'b1;
        case (mk)
            kbd_pkg::MK_LSHIFT, kbd_pkg::MK_RSHIFT: begin
                flags_next.shift    = press;
                dec_event.key_value = kbd_pkg::KV_LSHIFT;
            end
            kbd_pkg::MK_CTRL: begin
                flags_next.ctrl     = press;
                dec_event.key_value = kbd_pkg::KV_LCTRL;
            end
            kbd_pkg::MK_ALT: begin
                flags_next.alt      = press;
                dec_event.key_value = kbd_pkg::KV_LALT;
            end
            kbd_pkg::MK_CAPS: begin
                flags_next.caps     = flags.caps ^ press;
                dec_event.key_value = kbd_pkg::KV_CAPS;
            end
            default: begin
                if (nav_hit) begin
                    dec_event.key_value = nav_key;
                end else begin
                    // Only presses of codes covered by the tables produce a character.
                    dec_event.key_value = {2'b00, c3};
                    dec_event.emit      = press && (mk < kbd_pkg::MK_F1);
                end
            end
        endcase
    end

endmodule

// File: rtl/core/keyboard_scancode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder: scancode set 1 byte to key event decoder
// Tracks shift, ctrl, alt and caps lock and emits one event per relevant byte.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one raw scancode byte per transaction. Bit 7 of
//   the byte marks a key release. The master stream carries at most one key
//   event per input byte. Modifier and caps keys always produce an event,
//   navigation and function keys produce one on press and on release, and
//   table keys produce one only on press. Other bytes are consumed without
//   an event.
//
//   A byte is captured in an input register, decoded by short combinational
//   logic and written to the output register once that register is free or
//   draining; m_tvalid is driven from the output register. While the
//   receiver does not stall, one byte can be accepted in every cycle,
//   because the input register hands its byte on in the same cycle that the
//   output register is emptied.
//
//   The modifier flags carried in each event are the flags as they were
//   before that byte was applied. Reset clears all flags and both stages.
//   When the receiver stalls, the event holds on the master stream while one
//   more byte waits in the input register; s_tready drops only when both
//   stages are occupied.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave stream. tdata: [7:0] scan_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Master stream. tdata: [7:0] raw_code, [16:8] key_value, [17] is_press,
    // [18] shift_held, [19] ctrl_held, [20] alt_held, [23:21] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [kbd_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [7:0]                    in_byte_reg;
    kbd_pkg::mod_flags_t           flags_reg;
    kbd_pkg::mod_flags_t           flags_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [kbd_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [kbd_pkg::M_TDATA_W-1:0] out_data_next;
    kbd_pkg::dec_event_t           dec_event;
    kbd_pkg::mod_flags_t           decode_flags;
    logic                          advance;
    logic                          s_accept;

    kbd_decode u_decode (
        .scan_byte  (in_byte_reg),
        .flags      (flags_reg),
        .dec_event  (dec_event),
        .flags_next (decode_flags)
    );

    // The held byte moves on when the output register is free or draining.
    // Bytes that cause no event move on too and leave only their flag update.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        flags_next = advance ? decode_flags : flags_reg;

        out_valid_next = out_valid_reg;
        if (advance && dec_event.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        out_data_next = {3'b000, flags_reg.alt, flags_reg.ctrl, flags_reg.shift,
                         dec_event.is_press, dec_event.key_value, in_byte_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && dec_event.emit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/core/kbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_checker: port level checks for the scancode decoder
// Watches the master stream for reset, stall and event consistency rules.
// ----------------------------------------------------------------------------
module kbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [kbd_pkg::M_TDATA_W-1:0] m_tdata
);

    // Reset empties the output stage.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("event valid after reset");

    a_stall_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("event dropped while stalled");

    a_stall_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("event changed while stalled");

    // The press flag must agree with the release bit of the raw byte.
    a_press_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17] == !m_tdata[7]))
        else $error("press flag disagrees with raw code");

    // Characters appear only on press and stay within seven bits.
    a_char_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[16] |-> m_tdata[17] && !m_tdata[15])
        else $error("character event on release or out of range");

endmodule

bind keyboard_scancode_decoder kbd_checker u_kbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_keyboard_scancode_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_scancode_decoder: self-checking bench for the scancode decoder
// Feeds set 1 scancode bytes through the slave stream and compares every key
// event on the master stream against an independent decoder with its own
// modifier flags. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keyboard_scancode_decoder;

    // Timing of the run.
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_SCANS   = 2000;
    localparam int LONG_HOLD      = 60;    // receiver hold-off in the pressure phase
    localparam int BACKLOG_SCANS  = 40;    // bytes offered while the receiver holds off
    localparam int END_SETTLE     = 8;     // idle time after the final drain, before the verdict
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side

    // Make codes used by name in the directed part.
    localparam logic [6:0] MK_KEY_HOLE = 7'h00;
    localparam logic [6:0] MK_KEY_1    = 7'h02;
    localparam logic [6:0] MK_KEY_A    = 7'h1e;
    localparam logic [6:0] MK_KEY_Z    = 7'h2c;
    localparam logic [6:0] MK_UNMAPPED = 7'h45;
    localparam logic [6:0] MK_LAST     = 7'h7f;

    // The ASCII tables cover make codes below F1.
    localparam int KEY_TABLE_LEN = 59;

    localparam logic [7:0] PLAIN_KEYS [0:KEY_TABLE_LEN-1] = '{
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00
    };

    localparam logic [7:0] SHIFTED_KEYS [0:KEY_TABLE_LEN-1] = '{
        8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00
    };

    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CASE_SHIFT = 8'd32;
    localparam logic [7:0] CTRL_SHIFT = 8'd96;

    localparam logic [6:0] MODIFIER_KEYS [0:4] = '{
        kbd_pkg::MK_LSHIFT, kbd_pkg::MK_RSHIFT, kbd_pkg::MK_CTRL,
        kbd_pkg::MK_ALT, kbd_pkg::MK_CAPS
    };

    // One key event as it appears on the master stream.
    typedef struct {
        logic [7:0] raw;
        logic [8:0] key;
        logic       press;
        logic       shift;
        logic       ctrl;
        logic       alt;
    } event_rec_t;

    // Keeps its own modifier flags, decodes every accepted byte and holds the
    // key events that the block still owes, oldest first.
    class event_board;
        bit         shift_down;
        bit         ctrl_on;
        bit         alt_on;
        bit         caps_on;
        event_rec_t owed_events[$];
        int         errors;

        function logic [8:0] special_code(logic [6:0] mk);
            case (mk)
                kbd_pkg::MK_HOME:   return kbd_pkg::KV_HOME;
                kbd_pkg::MK_UP:     return kbd_pkg::KV_UP;
                kbd_pkg::MK_PGUP:   return kbd_pkg::KV_PGUP;
                kbd_pkg::MK_LEFT:   return kbd_pkg::KV_LEFT;
                kbd_pkg::MK_RIGHT:  return kbd_pkg::KV_RIGHT;
                kbd_pkg::MK_END:    return kbd_pkg::KV_END;
                kbd_pkg::MK_DOWN:   return kbd_pkg::KV_DOWN;
                kbd_pkg::MK_PGDN:   return kbd_pkg::KV_PGDN;
                kbd_pkg::MK_INSERT: return kbd_pkg::KV_INSERT;
                kbd_pkg::MK_DELETE: return kbd_pkg::KV_DELETE;
                kbd_pkg::MK_F11:    return kbd_pkg::KV_F11;
                kbd_pkg::MK_F12:    return kbd_pkg::KV_F12;
                default: begin
                    if (mk >= kbd_pkg::MK_F1 && mk <= kbd_pkg::MK_F10)
                        return kbd_pkg::KV_F1 + 9'(mk - kbd_pkg::MK_F1);
                    return 9'd0;
                end
            endcase
        endfunction

        // Decodes one accepted byte, updates the flags and queues the event.
        function void note_scan(logic [7:0] sc);
            event_rec_t ev;
            logic [6:0] mk;
            logic [7:0] ch;
            bit         emits;
            mk       = sc[6:0];
            emits    = 1'b1;
            ev.raw   = sc;
            ev.press = ~sc[7];
            // The event reports the flags from before this byte.
            ev.shift = shift_down;
            ev.ctrl  = ctrl_on;
            ev.alt   = alt_on;
            case (mk)
                kbd_pkg::MK_LSHIFT, kbd_pkg::MK_RSHIFT: begin
                    shift_down = ev.press;
                    ev.key     = kbd_pkg::KV_LSHIFT;
                end
                kbd_pkg::MK_CTRL: begin
                    ctrl_on = ev.press;
                    ev.key  = kbd_pkg::KV_LCTRL;
                end
                kbd_pkg::MK_ALT: begin
                    alt_on = ev.press;
                    ev.key = kbd_pkg::KV_LALT;
                end
                kbd_pkg::MK_CAPS: begin
                    if (ev.press)
                        caps_on = ~caps_on;
                    ev.key = kbd_pkg::KV_CAPS;
                end
                default: begin
                    ev.key = special_code(mk);
                    if (ev.key == 9'd0) begin
                        if (!ev.press || mk >= KEY_TABLE_LEN) begin
                            emits = 1'b0;
                        end else begin
                            ch = shift_down ? SHIFTED_KEYS[mk] : PLAIN_KEYS[mk];
                            if (caps_on && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                                ch = ch - CASE_SHIFT;
                            // Shift cancels caps lock for letters.
                            if (caps_on && shift_down && ch >= CH_UPPER_A
                                && ch <= CH_UPPER_Z)
                                ch = ch + CASE_SHIFT;
                            if (ctrl_on && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                                ch = ch - CTRL_SHIFT;
                            ev.key = {1'b0, ch};
                        end
                    end
                end
            endcase
            if (emits)
                owed_events.push_back(ev);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted key event against the oldest owed event.
        function void check_event(logic [kbd_pkg::M_TDATA_W-1:0] td);
            event_rec_t ev;
            if (owed_events.size() == 0) begin
                $error("key event %h arrived with none pending", td);
                errors++;
                return;
            end
            ev = owed_events.pop_front();
            compare_field("raw_code",   ev.raw,   td[7:0]);
            compare_field("key_value",  ev.key,   td[16:8]);
            compare_field("is_press",   ev.press, td[17]);
            compare_field("shift_held", ev.shift, td[18]);
            compare_field("ctrl_held",  ev.ctrl,  td[19]);
            compare_field("alt_held",   ev.alt,   td[20]);
        endfunction

        function int pending();
            return owed_events.size();
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;    // [7:0] scan_byte
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [kbd_pkg::M_TDATA_W-1:0] m_tdata;    // [7:0] raw_code, [16:8] key_value,
                                               // [17] is_press, [18] shift_held,
                                               // [19] ctrl_held, [20] alt_held

    event_board board = new();

    // Sender pacing: bytes go out in bursts; gapless suppresses the gaps.
    int burst_left = 0;
    bit gapless    = 1'b0;
    // Set by the stimulus to make the receiver hold off; LONG_HOLD sets how long.
    bit hold_req   = 1'b0;
    int idle_cycles = 0;

    keyboard_scancode_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Both streams are sampled at the rising edge, before any of the
    // nonblocking updates of that edge land, so the values seen here are
    // the ones the block saw. A byte is noted before an event is checked,
    // which keeps the order right even if the two meet in one cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_scan(s_tdata);
            if (m_tvalid && m_tready)
                board.check_event(m_tdata);
        end
    end

    // Watchdog: a correct block never goes this long without a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL keyboard_scancode_decoder");
                $finish;
            end
        end
    end

    // Receiver: segments of random length, each with its own stall pattern.
    // A hold request from the stimulus overrides the pattern for a long
    // stretch so that both stages of the block fill and s_tready drops.
    initial begin
        int mode;
        int seg_len;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            for (int i = 0; i < seg_len; i++) begin
                @(posedge aclk);
                if (hold_req) begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    hold_req = 1'b0;
                    m_tready <= 1'b1;
                end else begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= (i % 3) != 0;
                        default: m_tready <= $urandom_range(0, 9) != 0;
                    endcase
                end
            end
        end
    end

    function automatic logic [7:0] press_of(logic [6:0] mk);
        return {1'b0, mk};
    endfunction

    function automatic logic [7:0] release_of(logic [6:0] mk);
        return {1'b1, mk};
    endfunction

    // Offers one byte and returns at the edge where it is accepted. At the
    // start of each burst the sender may drop tvalid for a random gap.
    task automatic send_scan(logic [7:0] sc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every owed event has come out. The task
    // always waits for an edge, so tvalid is never lowered and raised in one step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    // Mostly realistic typing: letters and digits between modifier presses
    // and releases, navigation and function keys, plus raw noise bytes.
    function automatic logic [7:0] random_scan();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return {1'($urandom_range(0, 1)), MODIFIER_KEYS[$urandom_range(0, 4)]};
        if (pick < 60)
            return press_of(7'($urandom_range(0, KEY_TABLE_LEN - 1)));
        if (pick < 70)
            return release_of(7'($urandom_range(0, KEY_TABLE_LEN - 1)));
        if (pick < 85)
            return {1'($urandom_range(0, 1)),
                    7'($urandom_range(kbd_pkg::MK_F1, kbd_pkg::MK_F12))};
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The table hole maps to zero; its release is silent.
        send_scan(press_of(MK_KEY_HOLE));
        send_scan(release_of(MK_KEY_HOLE));
        send_scan(press_of(MK_KEY_A));
        send_scan(release_of(MK_KEY_A));
        // Both shift keys report as the left one.
        send_scan(press_of(kbd_pkg::MK_LSHIFT));
        send_scan(press_of(MK_KEY_A));
        send_scan(press_of(MK_KEY_1));
        send_scan(release_of(kbd_pkg::MK_LSHIFT));
        // Caps lock toggles on press only; shift then lowers a letter again.
        send_scan(press_of(kbd_pkg::MK_CAPS));
        send_scan(release_of(kbd_pkg::MK_CAPS));
        send_scan(press_of(MK_KEY_A));
        send_scan(press_of(kbd_pkg::MK_RSHIFT));
        send_scan(press_of(MK_KEY_Z));
        send_scan(release_of(kbd_pkg::MK_RSHIFT));
        // Ctrl leaves a caps-lock capital alone but turns a lowercase letter
        // into a control code.
        send_scan(press_of(kbd_pkg::MK_CTRL));
        send_scan(press_of(MK_KEY_A));
        send_scan(press_of(kbd_pkg::MK_CAPS));
        send_scan(press_of(MK_KEY_Z));
        send_scan(release_of(kbd_pkg::MK_CTRL));
        send_scan(press_of(kbd_pkg::MK_ALT));
        send_scan(press_of(kbd_pkg::MK_HOME));
        send_scan(release_of(kbd_pkg::MK_F10));
        send_scan(release_of(kbd_pkg::MK_ALT));
        send_scan(press_of(kbd_pkg::MK_F12));
        // Unmapped codes, including the largest byte values, emit nothing.
        send_scan(press_of(MK_UNMAPPED));
        send_scan(press_of(MK_LAST));
        send_scan(release_of(MK_LAST));
        wait_drained();

        for (int n = 0; n < RANDOM_SCANS; n++) begin
            if (n % 100 == 0)
                gapless = $urandom_range(0, 3) == 0;
            send_scan(random_scan());
            if (n == RANDOM_SCANS / 3) begin
                // Backlog: keep offering key presses while the receiver is
                // held off, then pause until the block has caught up.
                hold_req = 1'b1;
                gapless  = 1'b1;
                repeat (BACKLOG_SCANS)
                    send_scan(press_of(7'($urandom_range(0, KEY_TABLE_LEN - 1))));
                gapless = 1'b0;
                wait_drained();
            end else if (n % 500 == 499) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS keyboard_scancode_decoder");
        end else begin
            $display("FAIL keyboard_scancode_decoder");
        end
        $finish;
    end

endmodule
